// File: rtl/assert_macros.svh
// Assertion macros shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Property must hold at every clock edge outside reset.
`define VBSD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition must never be seen at a clock edge outside reset.
`define VBSD_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`else

`define VBSD_ASSERT(lbl, prop, msg)
`define VBSD_NEVER(lbl, cond, msg)

`endif

`endif

// File: rtl/vbsd_pkg.sv
// Types, block codes and ADPCM step function for the audio container stream decoder.
package vbsd_pkg;

  typedef enum logic [3:0] {
    PH_HEADER  = 4'd0,
    PH_TYPE    = 4'd1,
    PH_LEN0    = 4'd2,
    PH_LEN1    = 4'd3,
    PH_LEN2    = 4'd4,
    PH_RATE    = 4'd5,
    PH_COMP    = 4'd6,
    PH_SIL0    = 4'd7,
    PH_SIL1    = 4'd8,
    PH_SILRATE = 4'd9,
    PH_DATA    = 4'd10,
    PH_SKIP    = 4'd11
  } phase_e;

  typedef enum logic {
    KIND_SAMPLES = 1'b0,
    KIND_END     = 1'b1
  } item_kind_e;

  // Block type codes
  localparam logic [7:0] BLK_TERMINATOR = 8'h00;
  localparam logic [7:0] BLK_SOUND      = 8'h01;
  localparam logic [7:0] BLK_CONTINUE   = 8'h02;
  localparam logic [7:0] BLK_SILENCE    = 8'h03;

  // Compression codes
  localparam logic [7:0] COMP_PCM    = 8'h00;
  localparam logic [7:0] COMP_ADPCM4 = 8'h01;

  // The shift table clamped to 2..6 gives 2 for every nibble code.
  localparam logic [2:0] ADPCM_SHIFT = 3'd2;
  localparam logic [7:0] LEVEL_MAX   = 8'hff;

  localparam int unsigned MAX_RESULTS = 3;

  typedef struct packed {
    item_kind_e  kind;
    logic [7:0]  value;
    logic [16:0] repeat_count;
    logic        last;
  } result_t;

  // Results produced by one input transaction.
  typedef struct packed {
    logic [1:0]                    count;
    result_t [MAX_RESULTS-1:0]     res;
  } push_t;

  function automatic logic [7:0] adpcm_step(input logic [7:0] level,
                                            input logic [3:0] nib,
                                            input logic [2:0] shift);
    logic [9:0]  mag;
    logic [10:0] sum;
    logic [7:0]  next;
    mag = 10'(nib[2:0]) << shift;
    sum = 11'(level) + 11'(mag);
    if (nib[3]) begin
      next = (10'(level) > mag) ? 8'(10'(level) - mag) : 8'h00;
    end else begin
      next = (sum > 11'(LEVEL_MAX)) ? LEVEL_MAX : sum[7:0];
    end
    return next;
  endfunction

endpackage

// File: rtl/vbsd_parser.sv
// Block parser and ADPCM expander: turns one accepted byte into up to three results.
module vbsd_parser #(
  parameter int unsigned HEADER_BYTES = 26
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic [7:0]        data_byte_i,
  input  logic              file_start_i,
  input  logic              final_byte_i,
  output vbsd_pkg::push_t   push_o
);

  localparam logic [4:0] HdrLen = 5'(HEADER_BYTES);
  localparam vbsd_pkg::phase_e PhaseInit =
    (HEADER_BYTES == 0) ? vbsd_pkg::PH_TYPE : vbsd_pkg::PH_HEADER;

  vbsd_pkg::phase_e phase_q, phase_d, phase_c;
  logic [4:0]  hdr_cnt_q, hdr_cnt_d, hdr_cnt_c;
  logic [7:0]  kind_q, kind_d, kind_c;
  logic [23:0] len_q, len_d, len_c;
  logic [23:0] rem_q, rem_d, rem_c;
  logic [7:0]  comp_q, comp_d, comp_c;
  logic        ref_valid_q, ref_valid_d, ref_valid_c;
  logic [7:0]  level_q, level_d, level_c;
  logic [2:0]  shift_q, shift_d, shift_c;
  logic        ended_q, ended_d, ended_c;

  vbsd_pkg::push_t push;

  always_comb begin
    logic [1:0]  n;
    logic [23:0] len_new;
    logic [23:0] rem_dec;
    logic [7:0]  lvl_hi;
    logic [7:0]  lvl_lo;

    // A file start clears all state before this byte is parsed.
    phase_c     = file_start_i ? PhaseInit : phase_q;
    hdr_cnt_c   = file_start_i ? 5'd0  : hdr_cnt_q;
    kind_c      = file_start_i ? 8'd0  : kind_q;
    len_c       = file_start_i ? 24'd0 : len_q;
    rem_c       = file_start_i ? 24'd0 : rem_q;
    comp_c      = file_start_i ? 8'd0  : comp_q;
    ref_valid_c = file_start_i ? 1'b0  : ref_valid_q;
    level_c     = file_start_i ? 8'd0  : level_q;
    shift_c     = file_start_i ? 3'd0  : shift_q;
    ended_c     = file_start_i ? 1'b0  : ended_q;

    phase_d     = phase_c;
    hdr_cnt_d   = hdr_cnt_c;
    kind_d      = kind_c;
    len_d       = len_c;
    rem_d       = rem_c;
    comp_d      = comp_c;
    ref_valid_d = ref_valid_c;
    level_d     = level_c;
    shift_d     = shift_c;
    ended_d     = ended_c;

    n       = 2'd0;
    push    = '0;
    len_new = len_c | {data_byte_i, 16'h0000};
    rem_dec = rem_c - 24'd1;
    lvl_hi  = vbsd_pkg::adpcm_step(level_c, data_byte_i[7:4], shift_c);
    lvl_lo  = vbsd_pkg::adpcm_step(lvl_hi, data_byte_i[3:0], vbsd_pkg::ADPCM_SHIFT);

    if (!ended_c) begin
      unique case (phase_c)
        vbsd_pkg::PH_HEADER: begin
          hdr_cnt_d = hdr_cnt_c + 5'd1;
          if (hdr_cnt_d >= HdrLen) phase_d = vbsd_pkg::PH_TYPE;
        end
        vbsd_pkg::PH_TYPE: begin
          kind_d = data_byte_i;
          if (data_byte_i == vbsd_pkg::BLK_TERMINATOR) begin
            push.res[n] = '{kind: vbsd_pkg::KIND_END, value: 8'd0,
                            repeat_count: 17'd0, last: 1'b0};
            n = n + 2'd1;
            ended_d = 1'b1;
          end else if (data_byte_i == vbsd_pkg::BLK_SILENCE) begin
            phase_d = vbsd_pkg::PH_SIL0;
          end else begin
            phase_d = vbsd_pkg::PH_LEN0;
          end
        end
        vbsd_pkg::PH_LEN0: begin
          len_d   = {16'h0000, data_byte_i};
          phase_d = vbsd_pkg::PH_LEN1;
        end
        vbsd_pkg::PH_LEN1: begin
          len_d   = len_c | {8'h00, data_byte_i, 8'h00};
          phase_d = vbsd_pkg::PH_LEN2;
        end
        vbsd_pkg::PH_LEN2: begin
          len_d = len_new;
          if (kind_c == vbsd_pkg::BLK_SOUND) begin
            phase_d = vbsd_pkg::PH_RATE;
          end else if (kind_c == vbsd_pkg::BLK_CONTINUE) begin
            rem_d   = len_new;
            phase_d = (len_new != 24'd0) ? vbsd_pkg::PH_DATA : vbsd_pkg::PH_TYPE;
          end else begin
            rem_d   = len_new;
            phase_d = (len_new != 24'd0) ? vbsd_pkg::PH_SKIP : vbsd_pkg::PH_TYPE;
          end
        end
        vbsd_pkg::PH_RATE: begin
          phase_d = vbsd_pkg::PH_COMP;
        end
        vbsd_pkg::PH_COMP: begin
          comp_d = data_byte_i;
          if (data_byte_i != vbsd_pkg::COMP_PCM) ref_valid_d = 1'b0;
          // Length counts rate and compression bytes; a short one is an empty block.
          rem_d   = (len_c >= 24'd2) ? (len_c - 24'd2) : 24'd0;
          phase_d = (rem_d != 24'd0) ? vbsd_pkg::PH_DATA : vbsd_pkg::PH_TYPE;
        end
        vbsd_pkg::PH_SIL0: begin
          len_d   = {16'h0000, data_byte_i};
          phase_d = vbsd_pkg::PH_SIL1;
        end
        vbsd_pkg::PH_SIL1: begin
          len_d   = len_c | {8'h00, data_byte_i, 8'h00};
          phase_d = vbsd_pkg::PH_SILRATE;
        end
        vbsd_pkg::PH_SILRATE: begin
          push.res[n] = '{kind: vbsd_pkg::KIND_SAMPLES, value: 8'd0,
                          repeat_count: {1'b0, len_c[15:0]} + 17'd1, last: 1'b0};
          n = n + 2'd1;
          phase_d = vbsd_pkg::PH_TYPE;
        end
        vbsd_pkg::PH_DATA: begin
          if (comp_c == vbsd_pkg::COMP_PCM) begin
            push.res[n] = '{kind: vbsd_pkg::KIND_SAMPLES, value: data_byte_i,
                            repeat_count: 17'd1, last: 1'b0};
            n = n + 2'd1;
          end else if (comp_c == vbsd_pkg::COMP_ADPCM4) begin
            if (!ref_valid_c) begin
              level_d     = data_byte_i;
              ref_valid_d = 1'b1;
            end else begin
              // High nibble first, then the low nibble from the updated level.
              push.res[n] = '{kind: vbsd_pkg::KIND_SAMPLES, value: lvl_hi,
                              repeat_count: 17'd1, last: 1'b0};
              n = n + 2'd1;
              push.res[n] = '{kind: vbsd_pkg::KIND_SAMPLES, value: lvl_lo,
                              repeat_count: 17'd1, last: 1'b0};
              n = n + 2'd1;
              level_d = lvl_lo;
              shift_d = vbsd_pkg::ADPCM_SHIFT;
            end
          end else begin
            push.res[n] = '{kind: vbsd_pkg::KIND_SAMPLES, value: 8'd0,
                            repeat_count: 17'd1, last: 1'b0};
            n = n + 2'd1;
          end
          rem_d = rem_dec;
          if (rem_dec == 24'd0) phase_d = vbsd_pkg::PH_TYPE;
        end
        vbsd_pkg::PH_SKIP: begin
          rem_d = rem_dec;
          if (rem_dec == 24'd0) phase_d = vbsd_pkg::PH_TYPE;
        end
        default: begin
          phase_d = vbsd_pkg::PH_TYPE;
        end
      endcase

      if (final_byte_i && !ended_d) begin
        push.res[n] = '{kind: vbsd_pkg::KIND_END, value: 8'd0,
                        repeat_count: 17'd0, last: 1'b0};
        n = n + 2'd1;
        ended_d = 1'b1;
      end
    end

    // Flag the final result of this byte.
    for (int i = 0; i < vbsd_pkg::MAX_RESULTS; i++) begin
      push.res[i].last = (n != 2'd0) && (2'(i) == n - 2'd1);
    end
    push.count = n;
  end

  assign push_o = push;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PhaseInit;
      hdr_cnt_q   <= 5'd0;
      kind_q      <= 8'd0;
      len_q       <= 24'd0;
      rem_q       <= 24'd0;
      comp_q      <= 8'd0;
      ref_valid_q <= 1'b0;
      level_q     <= 8'd0;
      shift_q     <= 3'd0;
      ended_q     <= 1'b0;
    end else if (en_i) begin
      phase_q     <= phase_d;
      hdr_cnt_q   <= hdr_cnt_d;
      kind_q      <= kind_d;
      len_q       <= len_d;
      rem_q       <= rem_d;
      comp_q      <= comp_d;
      ref_valid_q <= ref_valid_d;
      level_q     <= level_d;
      shift_q     <= shift_d;
      ended_q     <= ended_d;
    end
  end

endmodule

// File: rtl/vbsd_result_fifo.sv
// Four-entry result queue: takes up to three results per cycle, hands out one.
module vbsd_result_fifo (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_en_i,
  input  vbsd_pkg::push_t   push_i,
  input  logic              pop_i,
  output vbsd_pkg::result_t head_o,
  output logic              valid_o,
  output logic              room_o
);

  localparam int unsigned Depth = 4;

  vbsd_pkg::result_t mem_q [Depth];
  logic [1:0] wr_ptr_q, wr_ptr_d;
  logic [1:0] rd_ptr_q, rd_ptr_d;
  logic [2:0] fill_q, fill_d;
  logic [1:0] push_n;
  logic       pop;

  assign push_n  = push_en_i ? push_i.count : 2'd0;
  assign valid_o = (fill_q != 3'd0);
  assign pop     = pop_i && valid_o;
  assign head_o  = mem_q[rd_ptr_q];
  // Room for a full burst of three results.
  assign room_o  = (fill_q <= 3'd1);

  assign wr_ptr_d = wr_ptr_q + push_n;
  assign rd_ptr_d = rd_ptr_q + 2'(pop);
  assign fill_d   = fill_q + 3'(push_n) - 3'(pop);

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < vbsd_pkg::MAX_RESULTS; i++) begin
      if (2'(i) < push_n) mem_q[wr_ptr_q + 2'(i)] <= push_i.res[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 2'd0;
      rd_ptr_q <= 2'd0;
      fill_q   <= 3'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

endmodule

// File: rtl/voc_block_stream_decoder_unit.sv
// Top level of the byte-serial audio container decoder with 4-bit ADPCM expansion.
//
// Input stream: one container file byte per transaction in tdata; tuser marks the
// first byte of a file and restarts the parser, tlast marks the final byte.
// The parser skips the file header, walks the blocks and writes the results of
// each byte (none, one sample, two ADPCM samples, a silence run and/or an end
// item) into a four-entry result queue in the same cycle it accepts the byte.
// Output stream: one result per transaction; tdata carries sample and repeat
// count, tuser the item kind (0 samples, 1 end of stream), tlast flags the last
// result caused by the input byte.
// A result is registered into the queue and presented once the results ahead
// of it have left. Throughput: one byte per cycle while each byte yields at
// most one result and the receiver takes every result; bytes that yield more
// results are drained one at a time by the single output port.
// Ready on the input is high while the queue holds at most one result, so a
// byte is still taken while a result waits; a stalled receiver fills the queue
// and then holds ready low. Reset empties the queue and returns the parser to
// the header-skip phase with no ADPCM reference.
`include "assert_macros.svh"

module voc_block_stream_decoder_unit #(
  parameter int unsigned HEADER_BYTES = 26
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] data_byte
  input  logic        s_axis_tuser_i,   // [0] file_start
  input  logic        s_axis_tlast_i,   // final_byte
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o,   // [7:0] sample_value, [24:8] repeat_count
  output logic        m_axis_tuser_o,   // [0] item_kind
  output logic        m_axis_tlast_o    // last_of_run
);

  logic              in_fire;
  vbsd_pkg::push_t   push;
  vbsd_pkg::result_t head;

  assign in_fire = s_axis_tvalid_i && s_axis_tready_o;

  vbsd_parser #(
    .HEADER_BYTES(HEADER_BYTES)
  ) u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .en_i         (in_fire),
    .data_byte_i  (s_axis_tdata_i),
    .file_start_i (s_axis_tuser_i),
    .final_byte_i (s_axis_tlast_i),
    .push_o       (push)
  );

  vbsd_result_fifo u_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_en_i (in_fire),
    .push_i    (push),
    .pop_i     (m_axis_tready_i),
    .head_o    (head),
    .valid_o   (m_axis_tvalid_o),
    .room_o    (s_axis_tready_o)
  );

  assign m_axis_tdata_o = {7'd0, head.repeat_count, head.value};
  assign m_axis_tuser_o = head.kind;
  assign m_axis_tlast_o = head.last;

  `VBSD_ASSERT(a_end_is_last, m_axis_tvalid_o && m_axis_tuser_o |-> m_axis_tlast_o, "end item not last of its byte")
  `VBSD_ASSERT(a_end_is_empty, m_axis_tvalid_o && m_axis_tuser_o |-> m_axis_tdata_o == 32'd0, "end item carries data")
  `VBSD_NEVER(a_stall_without_result, !s_axis_tready_o && !m_axis_tvalid_o, "input stalled with empty queue")
  `VBSD_ASSERT(a_sample_count, m_axis_tvalid_o && !m_axis_tuser_o |-> m_axis_tdata_o[24:8] != 17'd0, "sample run with zero count")

endmodule

// File: bench/voc_block_stream_decoder_unit_test.sv
// Stream-level testbench for the audio container decoder: scripted bytes, random files, own predictor.
`timescale 1ns / 100ps

module voc_block_stream_decoder_unit_test;

  localparam int          CLK_PERIOD   = 10;
  localparam int          HDR_LEN      = 26;
  localparam int          RANDOM_BYTES = 290;
  localparam int          QUIET_FROM   = 260;
  localparam int          QUIET_TO     = 380;
  localparam int          HOLD_AT      = 400;
  localparam int          HOLD_CYCLES  = 80;
  localparam int          STALL_LIMIT  = 1000;
  localparam logic [2:0]  SHIFT_LATER  = 3'd2;
  localparam logic [7:0]  BLK_OTHER    = 8'h09;
  localparam logic [7:0]  COMP_OTHER   = 8'h05;

  typedef enum logic [1:0] {
    CHK_PRED,
    CHK_NONE,
    CHK_ONE
  } check_e;

  typedef struct packed {
    vbsd_pkg::item_kind_e kind;
    logic [7:0]           value;
    logic [16:0]          count;
    logic                 last;
  } decoded_item_t;

  typedef struct {
    logic [7:0]           b;
    logic                 st;
    logic                 fin;
    int                   reps;
    check_e               chk;
    vbsd_pkg::item_kind_e kind;
    logic [7:0]           value;
    logic [16:0]          count;
  } script_row_t;

  typedef struct {
    logic [7:0] b;
    logic       st;
    logic       fin;
  } file_byte_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = 8'h00;
  logic        s_axis_tuser = 1'b0;
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;
  logic        m_axis_tuser;
  logic        m_axis_tlast;

  // Predictor state
  vbsd_pkg::phase_e dec_phase;
  logic [4:0]  hdr_cnt;
  logic [7:0]  blk_kind;
  logic [23:0] len_acc;
  logic [23:0] remaining;
  logic [7:0]  comp_code;
  logic        ref_ok;
  logic [7:0]  adpcm_lvl;
  logic [2:0]  shift_amt;
  logic        ended;

  decoded_item_t pending_items[$];
  file_byte_t    file_bytes[$];
  int unsigned   error_count = 0;
  int unsigned   bytes_fed = 0;
  int unsigned   byte_results = 0;
  int unsigned   quiet_cycles = 0;
  bit            no_idle = 1'b0;
  bit            hold_req = 1'b0;

  script_row_t script_rows[$] = '{
    // header after reset alone, no file start flag
    '{8'h00, 1'b0, 1'b0, 1, CHK_NONE, vbsd_pkg::KIND_SAMPLES, 8'h00, 17'd0},
    '{8'hff, 1'b0, 1'b0, 25, CHK_NONE, vbsd_pkg::KIND_SAMPLES, 8'h00, 17'd0},
    // longest silence run
    '{vbsd_pkg::BLK_SILENCE, 1'b0, 1'b0, 1, CHK_NONE, vbsd_pkg::KIND_SAMPLES, 8'h00, 17'd0},
    '{8'hff, 1'b0, 1'b0, 2, CHK_NONE, vbsd_pkg::KIND_SAMPLES, 8'h00, 17'd0},
    '{8'h00, 1'b0, 1'b0, 1, CHK_ONE, vbsd_pkg::KIND_SAMPLES, 8'h00, 17'h10000},
    // 8-bit sound, three data bytes
    '{vbsd_pkg::BLK_SOUND, 1'b0, 1'b0, 1, CHK_NONE, vbsd_pkg::KIND_SAMPLES, 8'h00, 17'd0},
    '{8'h05, 1'b0, 1'b0, 1, CHK_NONE, vbsd_pkg::KIND_SAMPLES, 8'h00, 17'd0},
    '{8'h00, 1'b0, 1'b0, 2, CHK_NONE, vbsd_pkg::KIND_SAMPLES, 8'h00, 17'd0},
    '{8'h80, 1'b0, 1'b0, 1, CHK_NONE, vbsd_pkg::KIND_SAMPLES, 8'h00, 17'd0},
    '{vbsd_pkg::COMP_PCM, 1'b0, 1'b0, 1, CHK_NONE, vbsd_pkg::KIND_SAMPLES, 8'h00, 17'd0},
    '{8'hff, 1'b0, 1'b0, 1, CHK_ONE, vbsd_pkg::KIND_SAMPLES, 8'hff, 17'd1},
    '{8'h00, 1'b0, 1'b0, 1, CHK_ONE, vbsd_pkg::KIND_SAMPLES, 8'h00, 17'd1},
    '{8'h5a, 1'b0, 1'b0, 1, CHK_PRED, vbsd_pkg::KIND_SAMPLES, 8'h00, 17'd0},
    // ADPCM sound: reference byte, then nibbles that clamp at the top
    '{vbsd_pkg::BLK_SOUND, 1'b0, 1'b0, 1, CHK_NONE, vbsd_pkg::KIND_SAMPLES, 8'h00, 17'd0},
    '{8'h06, 1'b0, 1'b0, 1, CHK_NONE, vbsd_pkg::KIND_SAMPLES, 8'h00, 17'd0},
    '{8'h00, 1'b0, 1'b0, 3, CHK_NONE, vbsd_pkg::KIND_SAMPLES, 8'h00, 17'd0},
    '{vbsd_pkg::COMP_ADPCM4, 1'b0, 1'b0, 1, CHK_NONE, vbsd_pkg::KIND_SAMPLES, 8'h00, 17'd0},
    '{8'hf0, 1'b0, 1'b0, 1, CHK_NONE, vbsd_pkg::KIND_SAMPLES, 8'h00, 17'd0},
    '{8'h77, 1'b0, 1'b0, 1, CHK_PRED, vbsd_pkg::KIND_SAMPLES, 8'h00, 17'd0},
    '{8'hff, 1'b0, 1'b0, 1, CHK_PRED, vbsd_pkg::KIND_SAMPLES, 8'h00, 17'd0},
    '{8'h88, 1'b0, 1'b0, 1, CHK_PRED, vbsd_pkg::KIND_SAMPLES, 8'h00, 17'd0},
    // empty continuation, then two more ADPCM bytes
    '{vbsd_pkg::BLK_CONTINUE, 1'b0, 1'b0, 1, CHK_NONE, vbsd_pkg::KIND_SAMPLES, 8'h00, 17'd0},
    '{8'h00, 1'b0, 1'b0, 3, CHK_NONE, vbsd_pkg::KIND_SAMPLES, 8'h00, 17'd0},
    '{vbsd_pkg::BLK_CONTINUE, 1'b0, 1'b0, 1, CHK_PRED, vbsd_pkg::KIND_SAMPLES, 8'h00, 17'd0},
    '{8'h02, 1'b0, 1'b0, 1, CHK_PRED, vbsd_pkg::KIND_SAMPLES, 8'h00, 17'd0},
    '{8'h00, 1'b0, 1'b0, 2, CHK_PRED, vbsd_pkg::KIND_SAMPLES, 8'h00, 17'd0},
    '{8'h8f, 1'b0, 1'b0, 1, CHK_PRED, vbsd_pkg::KIND_SAMPLES, 8'h00, 17'd0},
    '{8'hf8, 1'b0, 1'b0, 1, CHK_PRED, vbsd_pkg::KIND_SAMPLES, 8'h00, 17'd0},
    // sound block too short to hold data
    '{vbsd_pkg::BLK_SOUND, 1'b0, 1'b0, 1, CHK_PRED, vbsd_pkg::KIND_SAMPLES, 8'h00, 17'd0},
    '{8'h01, 1'b0, 1'b0, 1, CHK_PRED, vbsd_pkg::KIND_SAMPLES, 8'h00, 17'd0},
    '{8'h00, 1'b0, 1'b0, 2, CHK_PRED, vbsd_pkg::KIND_SAMPLES, 8'h00, 17'd0},
    '{8'hff, 1'b0, 1'b0, 1, CHK_PRED, vbsd_pkg::KIND_SAMPLES, 8'h00, 17'd0},
    '{vbsd_pkg::COMP_ADPCM4, 1'b0, 1'b0, 1, CHK_PRED, vbsd_pkg::KIND_SAMPLES, 8'h00, 17'd0},
    // unknown compression yields zero samples
    '{vbsd_pkg::BLK_SOUND, 1'b0, 1'b0, 1, CHK_NONE, vbsd_pkg::KIND_SAMPLES, 8'h00, 17'd0},
    '{8'h03, 1'b0, 1'b0, 1, CHK_NONE, vbsd_pkg::KIND_SAMPLES, 8'h00, 17'd0},
    '{8'h00, 1'b0, 1'b0, 3, CHK_NONE, vbsd_pkg::KIND_SAMPLES, 8'h00, 17'd0},
    '{COMP_OTHER, 1'b0, 1'b0, 1, CHK_NONE, vbsd_pkg::KIND_SAMPLES, 8'h00, 17'd0},
    '{8'hab, 1'b0, 1'b0, 1, CHK_ONE, vbsd_pkg::KIND_SAMPLES, 8'h00, 17'd1},
    // unrecognized block skipped by its length
    '{BLK_OTHER, 1'b0, 1'b0, 1, CHK_NONE, vbsd_pkg::KIND_SAMPLES, 8'h00, 17'd0},
    '{8'h02, 1'b0, 1'b0, 1, CHK_NONE, vbsd_pkg::KIND_SAMPLES, 8'h00, 17'd0},
    '{8'h00, 1'b0, 1'b0, 2, CHK_NONE, vbsd_pkg::KIND_SAMPLES, 8'h00, 17'd0},
    '{8'h11, 1'b0, 1'b0, 2, CHK_NONE, vbsd_pkg::KIND_SAMPLES, 8'h00, 17'd0},
    // shortest silence, terminator, then bytes past the end
    '{vbsd_pkg::BLK_SILENCE, 1'b0, 1'b0, 1, CHK_NONE, vbsd_pkg::KIND_SAMPLES, 8'h00, 17'd0},
    '{8'h00, 1'b0, 1'b0, 2, CHK_NONE, vbsd_pkg::KIND_SAMPLES, 8'h00, 17'd0},
    '{8'h7f, 1'b0, 1'b0, 1, CHK_ONE, vbsd_pkg::KIND_SAMPLES, 8'h00, 17'd1},
    '{vbsd_pkg::BLK_TERMINATOR, 1'b0, 1'b0, 1, CHK_ONE, vbsd_pkg::KIND_END, 8'h00, 17'd0},
    '{8'h42, 1'b0, 1'b1, 1, CHK_NONE, vbsd_pkg::KIND_SAMPLES, 8'h00, 17'd0},
    // new file that ends on its last header byte
    '{8'h55, 1'b1, 1'b0, 1, CHK_NONE, vbsd_pkg::KIND_SAMPLES, 8'h00, 17'd0},
    '{8'h00, 1'b0, 1'b0, 24, CHK_NONE, vbsd_pkg::KIND_SAMPLES, 8'h00, 17'd0},
    '{8'hff, 1'b0, 1'b1, 1, CHK_ONE, vbsd_pkg::KIND_END, 8'h00, 17'd0},
    // new file: huge sound block cut short by the final byte
    '{8'ha5, 1'b1, 1'b0, 1, CHK_NONE, vbsd_pkg::KIND_SAMPLES, 8'h00, 17'd0},
    '{8'ha5, 1'b0, 1'b0, 25, CHK_NONE, vbsd_pkg::KIND_SAMPLES, 8'h00, 17'd0},
    '{vbsd_pkg::BLK_SOUND, 1'b0, 1'b0, 1, CHK_PRED, vbsd_pkg::KIND_SAMPLES, 8'h00, 17'd0},
    '{8'hff, 1'b0, 1'b0, 4, CHK_PRED, vbsd_pkg::KIND_SAMPLES, 8'h00, 17'd0},
    '{vbsd_pkg::COMP_PCM, 1'b0, 1'b0, 1, CHK_PRED, vbsd_pkg::KIND_SAMPLES, 8'h00, 17'd0},
    '{8'h3c, 1'b0, 1'b1, 1, CHK_PRED, vbsd_pkg::KIND_SAMPLES, 8'h00, 17'd0}
  };

  voc_block_stream_decoder_unit #(
    .HEADER_BYTES(HDR_LEN)
  ) DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid),
    .s_axis_tready_o(s_axis_tready),
    .s_axis_tdata_i (s_axis_tdata),
    .s_axis_tuser_i (s_axis_tuser),
    .s_axis_tlast_i (s_axis_tlast),
    .m_axis_tvalid_o(m_axis_tvalid),
    .m_axis_tready_i(m_axis_tready),
    .m_axis_tdata_o (m_axis_tdata),
    .m_axis_tuser_o (m_axis_tuser),
    .m_axis_tlast_o (m_axis_tlast)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  function automatic void clear_decoder();
    dec_phase = (HDR_LEN == 0) ? vbsd_pkg::PH_TYPE : vbsd_pkg::PH_HEADER;
    hdr_cnt   = '0;
    blk_kind  = '0;
    len_acc   = '0;
    remaining = '0;
    comp_code = '0;
    ref_ok    = 1'b0;
    adpcm_lvl = '0;
    shift_amt = '0;
    ended     = 1'b0;
  endfunction

  function automatic void push_item(input vbsd_pkg::item_kind_e kind, input logic [7:0] value,
                                    input logic [16:0] count);
    pending_items.push_back('{kind, value, count, 1'b0});
  endfunction

  // One ADPCM nibble: scaled magnitude added or taken off, level held to 0..255.
  function automatic logic [7:0] next_level(input logic [3:0] nib);
    int lvl;
    int mag;
    lvl = int'(adpcm_lvl);
    mag = int'(nib[2:0]) << shift_amt;
    lvl = nib[3] ? lvl - mag : lvl + mag;
    if (lvl < 0) lvl = 0;
    if (lvl > 255) lvl = 255;
    adpcm_lvl = 8'(lvl);
    // every step table entry clamps up to the same shift
    shift_amt = SHIFT_LATER;
    return adpcm_lvl;
  endfunction

  function automatic void open_data(input logic [23:0] len);
    remaining = len;
    dec_phase = (len != 0) ? vbsd_pkg::PH_DATA : vbsd_pkg::PH_TYPE;
  endfunction

  // Work out the results of one accepted byte and queue them.
  function automatic void decode_byte(input logic [7:0] b, input logic st, input logic fin);
    int unsigned queued_at;
    logic [7:0]  sample;
    queued_at = pending_items.size();
    if (st) clear_decoder();
    if (!ended) begin
      case (dec_phase)
        vbsd_pkg::PH_HEADER: begin
          hdr_cnt = hdr_cnt + 5'd1;
          if (hdr_cnt >= HDR_LEN) dec_phase = vbsd_pkg::PH_TYPE;
        end
        vbsd_pkg::PH_TYPE: begin
          blk_kind = b;
          if (b == vbsd_pkg::BLK_TERMINATOR) begin
            push_item(vbsd_pkg::KIND_END, 8'h00, 17'd0);
            ended = 1'b1;
          end else if (b == vbsd_pkg::BLK_SILENCE) begin
            dec_phase = vbsd_pkg::PH_SIL0;
          end else begin
            dec_phase = vbsd_pkg::PH_LEN0;
          end
        end
        vbsd_pkg::PH_LEN0: begin
          len_acc   = {16'h0000, b};
          dec_phase = vbsd_pkg::PH_LEN1;
        end
        vbsd_pkg::PH_LEN1: begin
          len_acc[15:8] = b;
          dec_phase     = vbsd_pkg::PH_LEN2;
        end
        vbsd_pkg::PH_LEN2: begin
          len_acc[23:16] = b;
          if (blk_kind == vbsd_pkg::BLK_SOUND) begin
            dec_phase = vbsd_pkg::PH_RATE;
          end else if (blk_kind == vbsd_pkg::BLK_CONTINUE) begin
            open_data(len_acc);
          end else begin
            remaining = len_acc;
            dec_phase = (len_acc != 0) ? vbsd_pkg::PH_SKIP : vbsd_pkg::PH_TYPE;
          end
        end
        vbsd_pkg::PH_RATE: dec_phase = vbsd_pkg::PH_COMP;
        vbsd_pkg::PH_COMP: begin
          comp_code = b;
          if (b != vbsd_pkg::COMP_PCM) ref_ok = 1'b0;
          // the two header bytes of the block count in its length
          open_data((len_acc >= 24'd2) ? len_acc - 24'd2 : 24'd0);
        end
        vbsd_pkg::PH_SIL0: begin
          len_acc   = {16'h0000, b};
          dec_phase = vbsd_pkg::PH_SIL1;
        end
        vbsd_pkg::PH_SIL1: begin
          len_acc[15:8] = b;
          dec_phase     = vbsd_pkg::PH_SILRATE;
        end
        vbsd_pkg::PH_SILRATE: begin
          push_item(vbsd_pkg::KIND_SAMPLES, 8'h00, {1'b0, len_acc[15:0]} + 17'd1);
          dec_phase = vbsd_pkg::PH_TYPE;
        end
        vbsd_pkg::PH_DATA: begin
          if (comp_code == vbsd_pkg::COMP_PCM) begin
            push_item(vbsd_pkg::KIND_SAMPLES, b, 17'd1);
          end else if (comp_code == vbsd_pkg::COMP_ADPCM4) begin
            if (!ref_ok) begin
              adpcm_lvl = b;
              ref_ok    = 1'b1;
            end else begin
              sample = next_level(b[7:4]);
              push_item(vbsd_pkg::KIND_SAMPLES, sample, 17'd1);
              sample = next_level(b[3:0]);
              push_item(vbsd_pkg::KIND_SAMPLES, sample, 17'd1);
            end
          end else begin
            push_item(vbsd_pkg::KIND_SAMPLES, 8'h00, 17'd1);
          end
          remaining = remaining - 24'd1;
          if (remaining == 0) dec_phase = vbsd_pkg::PH_TYPE;
        end
        vbsd_pkg::PH_SKIP: begin
          remaining = remaining - 24'd1;
          if (remaining == 0) dec_phase = vbsd_pkg::PH_TYPE;
        end
        default: dec_phase = vbsd_pkg::PH_TYPE;
      endcase
      if (fin && !ended) begin
        push_item(vbsd_pkg::KIND_END, 8'h00, 17'd0);
        ended = 1'b1;
      end
    end
    byte_results = pending_items.size() - queued_at;
    if (byte_results != 0) pending_items[pending_items.size() - 1].last = 1'b1;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t ns: MISMATCH %s: got 0x%0h, want 0x%0h", $time, what, got, want);
    error_count++;
  endtask

  // Offer one byte and hold it until the transaction completes.
  task automatic send_byte(input logic [7:0] b, input logic st, input logic fin);
    if (bytes_fed == HOLD_AT) hold_req = 1'b1;
    no_idle = (bytes_fed >= QUIET_FROM) && (bytes_fed < QUIET_TO);
    @(negedge clk_i);
    if (!no_idle) begin
      while ($urandom_range(99) < 23) begin
        s_axis_tvalid <= 1'b0;
        @(negedge clk_i);
      end
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tuser  <= st;
    s_axis_tlast  <= fin;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    decode_byte(b, st, fin);
    bytes_fed++;
  endtask

  function automatic void add_byte(input logic [7:0] b, input logic st = 1'b0,
                                   input logic fin = 1'b0);
    file_bytes.push_back('{b, st, fin});
  endfunction

  // Build one random well-formed file, sometimes cut short.
  function automatic void build_file();
    int unsigned blocks;
    int unsigned pick;
    int unsigned len;
    logic [7:0]  code;
    logic [15:0] run;
    bit          cut;
    cut = 1'b0;
    file_bytes.delete();
    add_byte(8'($urandom), 1'b1);
    repeat (HDR_LEN - 1) add_byte(8'($urandom));
    blocks = $urandom_range(8, 2);
    for (int i = 0; i < int'(blocks) && !cut; i++) begin
      pick = $urandom_range(99);
      if (pick < 32) begin
        len  = $urandom_range(12);
        pick = $urandom_range(99);
        code = (pick < 45) ? vbsd_pkg::COMP_PCM :
               (pick < 85) ? vbsd_pkg::COMP_ADPCM4 : 8'($urandom_range(255, 2));
        add_byte(vbsd_pkg::BLK_SOUND);
        add_byte(8'(len));
        add_byte(8'h00);
        add_byte(8'h00);
        add_byte(8'($urandom));
        add_byte(code);
        repeat ((len > 2) ? len - 2 : 0) add_byte(8'($urandom));
      end else if (pick < 50) begin
        len = $urandom_range(8);
        add_byte(vbsd_pkg::BLK_CONTINUE);
        add_byte(8'(len));
        add_byte(8'h00);
        add_byte(8'h00);
        repeat (len) add_byte(8'($urandom));
      end else if (pick < 68) begin
        pick = $urandom_range(9);
        run  = (pick == 0) ? 16'hffff : (pick == 1) ? 16'h0000 : 16'($urandom);
        add_byte(vbsd_pkg::BLK_SILENCE);
        add_byte(run[7:0]);
        add_byte(run[15:8]);
        add_byte(8'($urandom));
      end else if (pick < 85) begin
        len = $urandom_range(5);
        add_byte(8'($urandom_range(255, 4)));
        add_byte(8'(len));
        add_byte(8'h00);
        add_byte(8'h00);
        repeat (len) add_byte(8'($urandom));
      end else begin
        // long block broken off by the final byte
        code = $urandom_range(1) ? vbsd_pkg::BLK_SOUND : vbsd_pkg::BLK_CONTINUE;
        add_byte(code);
        add_byte(8'($urandom));
        add_byte(8'($urandom));
        add_byte(8'($urandom_range(255, 1)));
        if (code == vbsd_pkg::BLK_SOUND) begin
          add_byte(8'($urandom));
          add_byte($urandom_range(1) ? vbsd_pkg::COMP_PCM : vbsd_pkg::COMP_ADPCM4);
        end
        repeat ($urandom_range(6, 1)) add_byte(8'($urandom));
        file_bytes[file_bytes.size() - 1].fin = 1'b1;
        cut = 1'b1;
      end
    end
    if (!cut) begin
      pick = $urandom_range(99);
      if (pick < 65) begin
        add_byte(vbsd_pkg::BLK_TERMINATOR, 1'b0, 1'($urandom_range(1)));
        repeat ($urandom_range(3)) add_byte(8'($urandom), 1'b0, 1'($urandom_range(1)));
      end else if (pick < 85) begin
        file_bytes[file_bytes.size() - 1].fin = 1'b1;
      end
      // otherwise the next file start breaks this one off
    end
  endfunction

  initial begin : stimulus
    int unsigned stop_at;
    clear_decoder();
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (script_rows[i]) begin
      for (int k = 0; k < script_rows[i].reps; k++) begin
        send_byte(script_rows[i].b, script_rows[i].st, script_rows[i].fin);
        if (script_rows[i].chk != CHK_PRED) begin
          // typed rows replace what the predictor queued for this byte
          repeat (byte_results) void'(pending_items.pop_back());
          if (script_rows[i].chk == CHK_ONE) begin
            pending_items.push_back('{script_rows[i].kind, script_rows[i].value,
                                      script_rows[i].count, 1'b1});
          end
        end
      end
    end

    stop_at = bytes_fed + RANDOM_BYTES;
    while (bytes_fed < stop_at) begin
      if ($urandom_range(9) == 0) begin
        repeat ($urandom_range(12, 4)) begin
          send_byte(8'($urandom), 1'($urandom_range(9) == 0), 1'($urandom_range(4) == 0));
        end
      end
      build_file();
      foreach (file_bytes[i]) send_byte(file_bytes[i].b, file_bytes[i].st, file_bytes[i].fin);
    end

    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pending_items.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Receiver: random stalls, a quiet stretch, and one long hold-off.
  initial begin : receiver
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        hold_req = 1'b0;
      end
      m_axis_tready <= no_idle || ($urandom_range(99) >= 23);
    end
  end

  always @(posedge clk_i) begin : result_check
    decoded_item_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_items.size() == 0) begin
        report_mismatch("result with nothing pending, tdata", m_axis_tdata, 32'h0);
      end else begin
        want = pending_items.pop_front();
        if (m_axis_tuser !== want.kind) report_mismatch("item_kind", m_axis_tuser, want.kind);
        if (m_axis_tdata[7:0] !== want.value) begin
          report_mismatch("sample_value", m_axis_tdata[7:0], want.value);
        end
        if (m_axis_tdata[24:8] !== want.count) begin
          report_mismatch("repeat_count", m_axis_tdata[24:8], want.count);
        end
        if (m_axis_tlast !== want.last) report_mismatch("last_of_run", m_axis_tlast, want.last);
      end
    end
  end

  // Abort when no transaction moves on either side for too long.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t ns: no transaction for %0d cycles", $time, STALL_LIMIT);
      $display("Test completed with failures");
      $finish;
    end
  end

endmodule

// File: filelist.f
+incdir+rtl
rtl/vbsd_pkg.sv
rtl/vbsd_parser.sv
rtl/vbsd_result_fifo.sv
rtl/voc_block_stream_decoder_unit.sv
bench/voc_block_stream_decoder_unit_test.sv
